// ===== rtl/core/hftq_pkg.sv =====
// Shared constants, opcodes and control types for the heightfield height query block.
package hftq_pkg;

    // Fixed field formats.
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = 7;
    localparam int HGT_W     = 16;
    localparam int CRD_W     = 16;
    localparam int GRID_W    = 8;

    // Configuration port layout.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;

    // Reset value of the grid size register.
    localparam logic [GRID_W-1:0] GRID_SIZE_RST = 8'd128;

    // Saturation limits of the height format.
    localparam logic signed [HGT_W-1:0] HGT_MAX = 16'sh7FFF;
    localparam logic signed [HGT_W-1:0] HGT_MIN = -16'sh8000;

    // Item opcodes.
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Bank selection for one store access.
    typedef struct packed
    {
        logic en;
        logic row_odd;
        logic col_odd;
    } bank_sel_t;

endpackage

// ===== rtl/core/hftq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module hftq_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hftq_map.sv =====
// Input stage: maps a query to cell space, checks its corners and forms read and write bank addresses.
module hftq_map
#(
    parameter int MAX_GRID = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic                              op,
    input  logic [hftq_pkg::POS_W-1:0]        row,
    input  logic [hftq_pkg::POS_W-1:0]        col,
    input  logic signed [hftq_pkg::HGT_W-1:0] height_in,
    input  logic signed [hftq_pkg::CRD_W-1:0] query_x,
    input  logic signed [hftq_pkg::CRD_W-1:0] query_z,
    input  logic [hftq_pkg::GRID_W-1:0]       grid_size,
    output hftq_pkg::bank_sel_t               rd_sel,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_row_even,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_row_odd,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_col_even,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_col_odd,
    output hftq_pkg::bank_sel_t               wr_sel,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] wr_row_hi,
    output logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] wr_col_hi,
    output logic [hftq_pkg::HGT_W-1:0]        wr_data,
    output logic                              q_valid,
    output logic                              q_oor,
    output logic [hftq_pkg::FRAC_BITS-1:0]    q_ds,
    output logic [hftq_pkg::FRAC_BITS-1:0]    q_dt
);

    localparam int IDXW   = ($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID);
    localparam int HALF_W = IDXW - 1;
    localparam int CW     = IDXW + 17;
    localparam int IW     = CW - hftq_pkg::FRAC_BITS;

    logic                              s1_valid_reg;
    logic                              s1_op_reg;
    logic [hftq_pkg::POS_W-1:0]        s1_row_reg;
    logic [hftq_pkg::POS_W-1:0]        s1_col_reg;
    logic [hftq_pkg::HGT_W-1:0]        s1_hgt_reg;
    logic signed [CW-1:0]              s1_cfix_reg;
    logic signed [CW-1:0]              s1_dfix_reg;

    logic [IW-1:0]                     grid_ext;
    logic [IW-1:0]                     eff_size;
    logic signed [IW-1:0]              lim;
    logic signed [CW-1:0]              half;
    logic signed [CW-1:0]              cfix_next;
    logic signed [CW-1:0]              dfix_next;
    logic signed [IW-1:0]              row_i;
    logic signed [IW-1:0]              col_i;
    logic [IDXW-1:0]                   r0;
    logic [IDXW-1:0]                   c0;
    logic [IDXW-1:0]                   wr_row;
    logic [IDXW-1:0]                   wr_col;
    logic                              write_ok;
    logic                              s1_query;
    logic                              s1_write;

    // Grid size in use, clamped to the store, and the half-grid offset.
    always_comb
    begin
        grid_ext = IW'(grid_size);
        eff_size = (grid_ext > IW'(MAX_GRID)) ? IW'(MAX_GRID) : grid_ext;
        lim      = eff_size - IW'(1);
        half     = CW'(eff_size) << (hftq_pkg::FRAC_BITS - 1);
    end

    // Cell-space coordinates of the incoming point.
    assign cfix_next = CW'(query_x) + half;
    assign dfix_next = half - CW'(query_z);

    // Stage 1 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= op;
            s1_row_reg  <= row;
            s1_col_reg  <= col;
            s1_hgt_reg  <= height_in;
            s1_cfix_reg <= cfix_next;
            s1_dfix_reg <= dfix_next;
        end
    end

    assign s1_query = s1_valid_reg && (s1_op_reg == hftq_pkg::OP_QUERY);
    assign s1_write = s1_valid_reg && (s1_op_reg == hftq_pkg::OP_WRITE);

    // Cell index and corner range check.
    always_comb
    begin
        row_i = s1_dfix_reg[CW-1:hftq_pkg::FRAC_BITS];
        col_i = s1_cfix_reg[CW-1:hftq_pkg::FRAC_BITS];
        q_oor = row_i[IW-1] || col_i[IW-1] || (row_i >= lim) || (col_i >= lim);
        q_ds  = s1_cfix_reg[hftq_pkg::FRAC_BITS-1:0];
        q_dt  = s1_dfix_reg[hftq_pkg::FRAC_BITS-1:0];
        r0    = row_i[IDXW-1:0];
        c0    = col_i[IDXW-1:0];
    end

    assign q_valid = s1_query;

    // Read addresses: the even bank takes the next row or column when the cell starts odd.
    assign rd_row_even = r0[IDXW-1:1] + HALF_W'(r0[0]);
    assign rd_row_odd  = r0[IDXW-1:1];
    assign rd_col_even = c0[IDXW-1:1] + HALF_W'(c0[0]);
    assign rd_col_odd  = c0[IDXW-1:1];
    assign rd_sel      = '{en: en && s1_query, row_odd: r0[0], col_odd: c0[0]};

    // Height writes; positions outside the store are dropped.
    assign write_ok  = (32'(s1_row_reg) < 32'(MAX_GRID)) && (32'(s1_col_reg) < 32'(MAX_GRID));
    assign wr_row    = IDXW'(s1_row_reg);
    assign wr_col    = IDXW'(s1_col_reg);
    assign wr_row_hi = wr_row[IDXW-1:1];
    assign wr_col_hi = wr_col[IDXW-1:1];
    assign wr_data   = s1_hgt_reg;
    assign wr_sel    = '{en: en && s1_write && write_ok, row_odd: wr_row[0], col_odd: wr_col[0]};

endmodule

// ===== rtl/core/hftq_store.sv =====
// Height store split into four row/column parity banks, so a cell's four corners read at once.
module hftq_store
#(
    parameter int MAX_GRID = 128
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hftq_pkg::bank_sel_t               rd_sel,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_row_even,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_row_odd,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_col_even,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] rd_col_odd,
    input  hftq_pkg::bank_sel_t               wr_sel,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] wr_row_hi,
    input  logic [((($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID)) - 1) - 1:0] wr_col_hi,
    input  logic [hftq_pkg::HGT_W-1:0]        wr_data,
    output logic signed [hftq_pkg::HGT_W-1:0] corner_a,
    output logic signed [hftq_pkg::HGT_W-1:0] corner_b,
    output logic signed [hftq_pkg::HGT_W-1:0] corner_c,
    output logic signed [hftq_pkg::HGT_W-1:0] corner_d
);

    localparam int IDXW   = ($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID);
    localparam int HALF_W = IDXW - 1;
    localparam int BANK_DEPTH = 2 ** (2 * HALF_W);

    logic [hftq_pkg::HGT_W-1:0] bank_rdata [4];
    logic                       par_row_reg;
    logic                       par_col_reg;

    // One RAM per parity combination; bank index is {row parity, column parity}.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK = 2'(b);

        logic [2*HALF_W-1:0] raddr;
        logic [2*HALF_W-1:0] waddr;
        logic                we;

        assign raddr = {(BANK[1] ? rd_row_odd : rd_row_even),
                        (BANK[0] ? rd_col_odd : rd_col_even)};
        assign waddr = {wr_row_hi, wr_col_hi};
        assign we    = wr_sel.en && (wr_sel.row_odd == BANK[1]) && (wr_sel.col_odd == BANK[0]);

        hftq_ram
        #(
            .WIDTH (hftq_pkg::HGT_W),
            .DEPTH (BANK_DEPTH)
        )
        u_ram
        (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wr_data),
            .re    (rd_sel.en),
            .raddr (raddr),
            .rdata (bank_rdata[b])
        );
    end

    // Cell parity follows the read data so the corners can be sorted out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_row_reg <= 1'b0;
            par_col_reg <= 1'b0;
        end
        else if (rd_sel.en)
        begin
            par_row_reg <= rd_sel.row_odd;
            par_col_reg <= rd_sel.col_odd;
        end
    end

    // Corner A sits in the cell's own parity bank; B, C and D flip column, row or both.
    assign corner_a = bank_rdata[{par_row_reg, par_col_reg}];
    assign corner_b = bank_rdata[{par_row_reg, ~par_col_reg}];
    assign corner_c = bank_rdata[{~par_row_reg, par_col_reg}];
    assign corner_d = bank_rdata[{~par_row_reg, ~par_col_reg}];

endmodule

// ===== rtl/core/hftq_interp.sv =====
// Triangle interpolation pipeline: operand select, products, rounding and saturation.
module hftq_interp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              q_valid,
    input  logic                              q_oor,
    input  logic [hftq_pkg::FRAC_BITS-1:0]    q_ds,
    input  logic [hftq_pkg::FRAC_BITS-1:0]    q_dt,
    input  logic signed [hftq_pkg::HGT_W-1:0] corner_a,
    input  logic signed [hftq_pkg::HGT_W-1:0] corner_b,
    input  logic signed [hftq_pkg::HGT_W-1:0] corner_c,
    input  logic signed [hftq_pkg::HGT_W-1:0] corner_d,
    output logic                              out_valid,
    output logic signed [hftq_pkg::HGT_W-1:0] height_out,
    output logic                              out_of_range
);

    localparam int FB    = hftq_pkg::FRAC_BITS;
    localparam int WW    = FB + 1;
    localparam int DW    = hftq_pkg::HGT_W + 1;
    localparam int PW    = DW + WW + 1;
    localparam int SUM_W = PW + 2;
    localparam int RW    = SUM_W - FB;
    localparam logic [WW-1:0]    ONE  = WW'(1) << FB;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FB - 1);

    // Stage 2: cell fractions, aligned with the store read data.
    logic                        v2_reg;
    logic                        oor2_reg;
    logic [FB-1:0]               ds2_reg;
    logic [FB-1:0]               dt2_reg;

    // Stage 3: triangle operands.
    logic                        v3_reg;
    logic                        oor3_reg;
    logic signed [hftq_pkg::HGT_W-1:0] base3_reg;
    logic [WW-1:0]               w1_3_reg;
    logic [WW-1:0]               w2_3_reg;
    logic signed [DW-1:0]        d1_3_reg;
    logic signed [DW-1:0]        d2_3_reg;

    // Stage 4: products.
    logic                        v4_reg;
    logic                        oor4_reg;
    logic signed [hftq_pkg::HGT_W-1:0] base4_reg;
    logic signed [PW-1:0]        p1_4_reg;
    logic signed [PW-1:0]        p2_4_reg;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_oor_reg;
    logic signed [hftq_pkg::HGT_W-1:0] out_hgt_reg;

    logic [WW-1:0]               ds_ext;
    logic [WW-1:0]               dt_ext;
    logic [WW-1:0]               frac_sum;
    logic                        lower;
    logic signed [hftq_pkg::HGT_W-1:0] base3_next;
    logic [WW-1:0]               w1_next;
    logic [WW-1:0]               w2_next;
    logic signed [DW-1:0]        d1_next;
    logic signed [DW-1:0]        d2_next;
    logic signed [PW-1:0]        p1_next;
    logic signed [PW-1:0]        p2_next;
    logic signed [SUM_W-1:0]     acc;
    logic signed [RW-1:0]        h_round;
    logic signed [hftq_pkg::HGT_W-1:0] h_next;

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg        <= q_valid;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // Pick the triangle and its edge weights from the cell fractions.
    always_comb
    begin
        ds_ext   = {1'b0, ds2_reg};
        dt_ext   = {1'b0, dt2_reg};
        frac_sum = ds_ext + dt_ext;
        lower    = !frac_sum[FB];
        if (lower)
        begin
            base3_next = corner_a;
            w1_next    = ds_ext;
            w2_next    = dt_ext;
            d1_next    = DW'(corner_b) - DW'(corner_a);
            d2_next    = DW'(corner_c) - DW'(corner_a);
        end
        else
        begin
            base3_next = corner_d;
            w1_next    = ONE - ds_ext;
            w2_next    = ONE - dt_ext;
            d1_next    = DW'(corner_c) - DW'(corner_d);
            d2_next    = DW'(corner_b) - DW'(corner_d);
        end
    end

    // Weighted edge differences.
    assign p1_next = $signed({1'b0, w1_3_reg}) * d1_3_reg;
    assign p2_next = $signed({1'b0, w2_3_reg}) * d2_3_reg;

    // Sum, round half up, then clamp to the height range; an out-of-range query gives zero.
    always_comb
    begin
        acc     = (SUM_W'(base4_reg) <<< FB) + SUM_W'(p1_4_reg) + SUM_W'(p2_4_reg)
                  + $signed(HALF);
        h_round = acc[SUM_W-1:FB];
        if (oor4_reg)
        begin
            h_next = '0;
        end
        else if (h_round > RW'(hftq_pkg::HGT_MAX))
        begin
            h_next = hftq_pkg::HGT_MAX;
        end
        else if (h_round < RW'(hftq_pkg::HGT_MIN))
        begin
            h_next = hftq_pkg::HGT_MIN;
        end
        else
        begin
            h_next = h_round[hftq_pkg::HGT_W-1:0];
        end
    end

    // Data registers of stages 2 to 4 and the output.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor2_reg    <= q_oor;
            ds2_reg     <= q_ds;
            dt2_reg     <= q_dt;
            oor3_reg    <= oor2_reg;
            base3_reg   <= base3_next;
            w1_3_reg    <= w1_next;
            w2_3_reg    <= w2_next;
            d1_3_reg    <= d1_next;
            d2_3_reg    <= d2_next;
            oor4_reg    <= oor3_reg;
            base4_reg   <= base3_reg;
            p1_4_reg    <= p1_next;
            p2_4_reg    <= p2_next;
            out_oor_reg <= oor4_reg;
            out_hgt_reg <= h_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_of_range = out_oor_reg;
    assign height_out   = out_hgt_reg;

endmodule

// ===== rtl/core/heightfield_triangle_height_query.sv =====
// Top level of the heightfield triangle height query block.
// The block takes one beat per cycle unless a result waits at the output, height writes
// and queries alike, and presents a query's result at the output; writes give no result.
// The store is held in four RAM banks by row and column parity, so the four corners of a
// cell are read together and a new query can be taken before the last one is through.
// The pipeline stalls as a whole only while a finished result waits at the output.
// Stored heights are undefined until written, and there is no clearing pass after reset.
// The grid size register may be written only while no beat is in flight.
module heightfield_triangle_height_query
#(
    parameter int MAX_GRID = 128
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hftq_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [hftq_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [hftq_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic [hftq_pkg::POS_W-1:0]             row,
    input  logic [hftq_pkg::POS_W-1:0]             col,
    input  logic signed [hftq_pkg::HGT_W-1:0]      height_in,
    input  logic signed [hftq_pkg::CRD_W-1:0]      query_x,
    input  logic signed [hftq_pkg::CRD_W-1:0]      query_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [hftq_pkg::HGT_W-1:0]      height_out,
    output logic                                   out_of_range
);

    localparam int IDXW   = ($clog2(MAX_GRID) < 2) ? 2 : $clog2(MAX_GRID);
    localparam int HALF_W = IDXW - 1;

    logic [hftq_pkg::GRID_W-1:0]    grid_size_reg;
    logic [hftq_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_we;
    logic                           en;

    hftq_pkg::bank_sel_t            rd_sel;
    hftq_pkg::bank_sel_t            wr_sel;
    logic [HALF_W-1:0]              rd_row_even;
    logic [HALF_W-1:0]              rd_row_odd;
    logic [HALF_W-1:0]              rd_col_even;
    logic [HALF_W-1:0]              rd_col_odd;
    logic [HALF_W-1:0]              wr_row_hi;
    logic [HALF_W-1:0]              wr_col_hi;
    logic [hftq_pkg::HGT_W-1:0]     wr_data;
    logic                           q_valid;
    logic                           q_oor;
    logic [hftq_pkg::FRAC_BITS-1:0] q_ds;
    logic [hftq_pkg::FRAC_BITS-1:0] q_dt;
    logic signed [hftq_pkg::HGT_W-1:0] corner_a;
    logic signed [hftq_pkg::HGT_W-1:0] corner_b;
    logic signed [hftq_pkg::HGT_W-1:0] corner_c;
    logic signed [hftq_pkg::HGT_W-1:0] corner_d;

    // Register decode on the word address.
    assign reg_idx = paddr[hftq_pkg::APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && (reg_idx == hftq_pkg::REG_GRID_SIZE);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= hftq_pkg::GRID_SIZE_RST;
        end
        else if (cfg_we)
        begin
            grid_size_reg <= pwdata[hftq_pkg::GRID_W-1:0];
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            hftq_pkg::REG_GRID_SIZE: prdata = hftq_pkg::APB_DATA_W'(grid_size_reg);
            default:                 prdata = '0;
        endcase
    end

    // The pipeline advances unless a result is held at the output.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    hftq_map
    #(
        .MAX_GRID (MAX_GRID)
    )
    u_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .op          (op),
        .row         (row),
        .col         (col),
        .height_in   (height_in),
        .query_x     (query_x),
        .query_z     (query_z),
        .grid_size   (grid_size_reg),
        .rd_sel      (rd_sel),
        .rd_row_even (rd_row_even),
        .rd_row_odd  (rd_row_odd),
        .rd_col_even (rd_col_even),
        .rd_col_odd  (rd_col_odd),
        .wr_sel      (wr_sel),
        .wr_row_hi   (wr_row_hi),
        .wr_col_hi   (wr_col_hi),
        .wr_data     (wr_data),
        .q_valid     (q_valid),
        .q_oor       (q_oor),
        .q_ds        (q_ds),
        .q_dt        (q_dt)
    );

    hftq_store
    #(
        .MAX_GRID (MAX_GRID)
    )
    u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_sel      (rd_sel),
        .rd_row_even (rd_row_even),
        .rd_row_odd  (rd_row_odd),
        .rd_col_even (rd_col_even),
        .rd_col_odd  (rd_col_odd),
        .wr_sel      (wr_sel),
        .wr_row_hi   (wr_row_hi),
        .wr_col_hi   (wr_col_hi),
        .wr_data     (wr_data),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .corner_d    (corner_d)
    );

    hftq_interp u_interp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .q_valid      (q_valid),
        .q_oor        (q_oor),
        .q_ds         (q_ds),
        .q_dt         (q_dt),
        .corner_a     (corner_a),
        .corner_b     (corner_b),
        .corner_c     (corner_c),
        .corner_d     (corner_d),
        .out_valid    (out_valid),
        .height_out   (height_out),
        .out_of_range (out_of_range)
    );

    // A single stage holds one beat, so the store is never read and written together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_sel.en && wr_sel.en))
    else $error("store read and write issued in the same cycle");

    // A query with a corner off the grid reports a zero height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (height_out == '0))
    else $error("out-of-range result carries a nonzero height");

    // Input back-pressure only comes from a result waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

    // Nothing in the pipeline moves while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (out_valid && $stable(height_out) && $stable(out_of_range)
                 && $stable(q_ds) && $stable(q_dt)))
    else $error("pipeline state changed during a stall");

endmodule

// ===== sim/heightfield_triangle_height_query_tb.sv =====
// Self-checking testbench for the heightfield triangle height query block.
module heightfield_triangle_height_query_tb;

    localparam int     STORE_SIDE       = 128;
    localparam longint ONE              = longint'(1) << hftq_pkg::FRAC_BITS;
    localparam int     DRAIN_CYCLES     = 12;
    localparam int     LONG_HOLD        = 300;
    localparam int     NUM_PHASES       = 10;
    localparam int     RANDOM_PER_PHASE = 120;
    localparam logic [hftq_pkg::APB_ADDR_W-1:0] GRID_SIZE_ADDR =
        hftq_pkg::APB_ADDR_W'(4 * int'(hftq_pkg::REG_GRID_SIZE));
    localparam int     PHASE_SIZES [NUM_PHASES] = '{2, 3, 128, 7, 0, 255, 16, 1, 64, 0};

    // One input beat, as the block sees it.
    typedef struct
    {
        hftq_pkg::op_t                     op;
        logic [hftq_pkg::POS_W-1:0]        row;
        logic [hftq_pkg::POS_W-1:0]        col;
        logic signed [hftq_pkg::HGT_W-1:0] height;
        logic signed [hftq_pkg::CRD_W-1:0] qx;
        logic signed [hftq_pkg::CRD_W-1:0] qz;
    } beat_t;

    // One expected query answer.
    typedef struct
    {
        logic signed [hftq_pkg::HGT_W-1:0] height;
        logic                              oor;
    } height_due_t;

    // Terrain model: mirrors the grid, predicts query heights and matches results.
    class terrain_height_model;
        logic signed [hftq_pkg::HGT_W-1:0] store [STORE_SIDE*STORE_SIDE];
        bit                                written [STORE_SIDE*STORE_SIDE];
        logic [hftq_pkg::GRID_W-1:0]       grid;
        height_due_t                       heights_due [$];
        int                                errors;

        function new();
            grid   = hftq_pkg::GRID_SIZE_RST;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function int eff_size();
            return (int'(grid) > STORE_SIDE) ? STORE_SIDE : int'(grid);
        endfunction

        // Map a point to its cell; returns 1 when all four corners lie in the grid.
        function bit locate(input logic signed [hftq_pkg::CRD_W-1:0] x,
                            input logic signed [hftq_pkg::CRD_W-1:0] z,
                            output longint rw, output longint cl);
            longint half;
            half = longint'(eff_size()) <<< (hftq_pkg::FRAC_BITS - 1);
            cl = (longint'(x) + half) >>> hftq_pkg::FRAC_BITS;
            rw = (half - longint'(z)) >>> hftq_pkg::FRAC_BITS;
            return rw >= 0 && cl >= 0 && rw + 1 < eff_size() && cl + 1 < eff_size();
        endfunction

        // Apply an accepted beat: writes update the grid, queries queue an answer.
        function void take_beat(beat_t b);
            longint      rw, cl, half, cf, df, ds, dt, a, bh, ch, dh, acc, h;
            int          base;
            height_due_t e;
            if (b.op == hftq_pkg::OP_WRITE)
            begin
                store[int'({b.row, b.col})]   = b.height;
                written[int'({b.row, b.col})] = 1'b1;
                return;
            end
            e.height = '0;
            e.oor    = 1'b1;
            if (locate(b.qx, b.qz, rw, cl))
            begin
                half = longint'(eff_size()) <<< (hftq_pkg::FRAC_BITS - 1);
                cf   = longint'(b.qx) + half;
                df   = half - longint'(b.qz);
                ds   = cf - (cl <<< hftq_pkg::FRAC_BITS);
                dt   = df - (rw <<< hftq_pkg::FRAC_BITS);
                base = int'(rw) * STORE_SIDE + int'(cl);
                a    = longint'(store[base]);
                bh   = longint'(store[base + 1]);
                ch   = longint'(store[base + STORE_SIDE]);
                dh   = longint'(store[base + STORE_SIDE + 1]);
                // Pick the triangle of the cell that holds the point.
                if (ds + dt < ONE)
                    acc = a * ONE + ds * (bh - a) + dt * (ch - a);
                else
                    acc = dh * ONE + (ONE - ds) * (ch - dh) + (ONE - dt) * (bh - dh);
                h = (acc + ONE / 2) >>> hftq_pkg::FRAC_BITS;
                if (h > longint'(hftq_pkg::HGT_MAX))
                    h = longint'(hftq_pkg::HGT_MAX);
                if (h < longint'(hftq_pkg::HGT_MIN))
                    h = longint'(hftq_pkg::HGT_MIN);
                e.height = h[hftq_pkg::HGT_W-1:0];
                e.oor    = 1'b0;
            end
            heights_due.push_back(e);
        endfunction

        // Compare one result beat with the oldest answer still due.
        task match_result(logic signed [hftq_pkg::HGT_W-1:0] h, logic oor);
            height_due_t e;
            if (heights_due.size() == 0)
            begin
                report($sformatf("result %0d/%0b with no query pending", h, oor));
                return;
            end
            e = heights_due.pop_front();
            if (h !== e.height)
                report($sformatf("height_out %0d, predicted %0d", h, e.height));
            if (oor !== e.oor)
                report($sformatf("out_of_range %0b, predicted %0b", oor, e.oor));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [hftq_pkg::APB_ADDR_W-1:0]   paddr;
    logic [hftq_pkg::APB_DATA_W-1:0]   pwdata;
    logic [hftq_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;
    logic                              in_valid;
    logic                              in_ready;
    logic                              op;
    logic [hftq_pkg::POS_W-1:0]        row;
    logic [hftq_pkg::POS_W-1:0]        col;
    logic signed [hftq_pkg::HGT_W-1:0] height_in;
    logic signed [hftq_pkg::CRD_W-1:0] query_x;
    logic signed [hftq_pkg::CRD_W-1:0] query_z;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [hftq_pkg::HGT_W-1:0] height_out;
    logic                              out_of_range;

    terrain_height_model model = new();
    int  beats_sent = 0;
    bit  calm       = 1'b0;
    bit  hold_req   = 1'b0;

    heightfield_triangle_height_query #(
        .MAX_GRID(STORE_SIDE)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .row         (row),
        .col         (col),
        .height_in   (height_in),
        .query_x     (query_x),
        .query_z     (query_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .height_out  (height_out),
        .out_of_range(out_of_range)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Gap length: mostly none or short, a few long; none while calm.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [hftq_pkg::HGT_W-1:0] rand_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return hftq_pkg::HGT_MAX;
        if (r < 10)
            return hftq_pkg::HGT_MIN;
        return hftq_pkg::HGT_W'($urandom);
    endfunction

    // Write beat; the unused coordinate fields carry noise.
    function automatic beat_t write_beat(logic [hftq_pkg::POS_W-1:0] r,
                                         logic [hftq_pkg::POS_W-1:0] c,
                                         logic signed [hftq_pkg::HGT_W-1:0] h);
        beat_t b;
        b.op     = hftq_pkg::OP_WRITE;
        b.row    = r;
        b.col    = c;
        b.height = h;
        b.qx     = hftq_pkg::CRD_W'($urandom);
        b.qz     = hftq_pkg::CRD_W'($urandom);
        return b;
    endfunction

    // One of the indexes around the rim of the grid.
    function automatic longint rim_index(int s);
        case ($urandom_range(0, 3))
            0:       return -1;
            1:       return 0;
            2:       return s - 2;
            default: return s - 1;
        endcase
    endfunction

    // Offer one beat and hold it until the block takes it.
    task automatic push_beat(input beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= b.op;
        row       <= b.row;
        col       <= b.col;
        height_in <= b.height;
        query_x   <= b.qx;
        query_z   <= b.qz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model.take_beat(b);
        beats_sent++;
    endtask

    // Query a point, first writing any corner of its cell that was never written.
    task automatic send_query(input logic signed [hftq_pkg::CRD_W-1:0] x,
                              input logic signed [hftq_pkg::CRD_W-1:0] z);
        longint rw, cl;
        int     idx;
        beat_t  b;
        if (model.locate(x, z, rw, cl))
        begin
            for (int dr = 0; dr < 2; dr++)
            begin
                for (int dc = 0; dc < 2; dc++)
                begin
                    idx = int'(rw + dr) * STORE_SIDE + int'(cl + dc);
                    if (!model.written[idx])
                        push_beat(write_beat(hftq_pkg::POS_W'(rw + dr),
                                             hftq_pkg::POS_W'(cl + dc), rand_height()));
                end
            end
        end
        b.op     = hftq_pkg::OP_QUERY;
        b.row    = hftq_pkg::POS_W'($urandom);
        b.col    = hftq_pkg::POS_W'($urandom);
        b.height = hftq_pkg::HGT_W'($urandom);
        b.qx     = x;
        b.qz     = z;
        push_beat(b);
    endtask

    // Query a cell at fractional offsets ds, dt under the current grid size.
    task automatic query_cell(input longint rw, input longint cl, input longint ds,
                              input longint dt);
        longint half, x, z;
        half = longint'(model.eff_size()) <<< (hftq_pkg::FRAC_BITS - 1);
        x    = cl * ONE + ds - half;
        z    = half - (rw * ONE + dt);
        send_query(hftq_pkg::CRD_W'(x), hftq_pkg::CRD_W'(z));
    endtask

    // Stop offering beats and wait until the block has drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (model.heights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [hftq_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GRID_SIZE_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(output logic [hftq_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= GRID_SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the grid size while idle, then read it back.
    task automatic set_grid(input logic [hftq_pkg::GRID_W-1:0] v);
        logic [hftq_pkg::APB_DATA_W-1:0] rd;
        settle();
        apb_write(hftq_pkg::APB_DATA_W'(v));
        model.grid = v;
        @(posedge clk);
        apb_read(rd);
        if (rd[hftq_pkg::GRID_W-1:0] !== v)
            model.report($sformatf("grid_size reads %0d, written %0d",
                                   rd[hftq_pkg::GRID_W-1:0], v));
    endtask

    // Result side: check every accepted result beat and stall at random.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                model.match_result(height_out, out_of_range);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // Main sequence: reset, directed beats, then random phases over several grid sizes.
    initial
    begin
        int                              sz, k, s, phase_end;
        longint                          ds, dt;
        logic [hftq_pkg::APB_DATA_W-1:0] rd;

        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        op        <= hftq_pkg::OP_WRITE;
        row       <= '0;
        col       <= '0;
        height_in <= '0;
        query_x   <= '0;
        query_z   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The grid size register comes out of reset at its default.
        apb_read(rd);
        if (rd[hftq_pkg::GRID_W-1:0] !== hftq_pkg::GRID_SIZE_RST)
            model.report($sformatf("grid_size after reset reads %0d",
                                   rd[hftq_pkg::GRID_W-1:0]));

        // Corner heights at the format extremes, at both ends of the store.
        push_beat(write_beat(0, 0, hftq_pkg::HGT_MAX));
        push_beat(write_beat(0, 1, hftq_pkg::HGT_MIN));
        push_beat(write_beat(1, 0, 16'sh0000));
        push_beat(write_beat(1, 1, 16'sh1234));
        push_beat(write_beat(127, 127, -16'sh0001));
        push_beat(write_beat(126, 126, 16'sh0100));
        push_beat(write_beat(126, 127, hftq_pkg::HGT_MAX));
        push_beat(write_beat(127, 126, hftq_pkg::HGT_MIN));

        // Both triangles, the diagonal itself and the cell corners.
        query_cell(0, 0, 0, 0);
        query_cell(0, 0, ONE - 1, 0);
        query_cell(0, 0, ONE / 2, ONE / 2);
        query_cell(0, 0, ONE / 2 - 1, ONE / 2);
        query_cell(0, 0, ONE - 1, ONE - 1);
        query_cell(126, 126, 0, ONE - 1);
        query_cell(126, 126, 200, 100);

        // Corners outside the grid on every side.
        send_query(hftq_pkg::HGT_MIN, 16'sh0000);
        send_query(hftq_pkg::HGT_MAX, 16'sh0000);
        send_query(16'sh0000, hftq_pkg::HGT_MAX);
        send_query(16'sh0000, hftq_pkg::HGT_MIN);
        query_cell(0, 127, 0, 0);
        query_cell(-1, 0, 10, 10);

        // Grids too small to hold a cell, an oversized grid, and the smallest real grid.
        set_grid(8'd0);
        query_cell(0, 0, 5, 5);
        set_grid(8'd1);
        query_cell(0, 0, 5, 5);
        set_grid(8'd255);
        query_cell(126, 126, 40, 40);
        set_grid(8'd2);
        query_cell(0, 0, 100, 50);
        query_cell(1, 0, 0, 0);

        // Random phases.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                sz = $urandom_range(2, 128);
            else
                sz = PHASE_SIZES[p];
            set_grid(hftq_pkg::GRID_W'(sz));
            calm = (p == 3 || p == 7);
            // Hold the result side off long enough to back up the pipeline.
            if (p == 2)
                hold_req = 1'b1;
            phase_end = beats_sent + RANDOM_PER_PHASE;
            s = model.eff_size();
            while (beats_sent < phase_end)
            begin
                k = $urandom_range(0, 99);
                if (k < 20)
                begin
                    if (s > 0 && k < 12)
                        push_beat(write_beat(hftq_pkg::POS_W'($urandom_range(0, s - 1)),
                                             hftq_pkg::POS_W'($urandom_range(0, s - 1)),
                                             rand_height()));
                    else
                        push_beat(write_beat(hftq_pkg::POS_W'($urandom),
                                             hftq_pkg::POS_W'($urandom), rand_height()));
                end
                else if (k < 70 && s >= 2)
                begin
                    ds = $urandom_range(0, ONE - 1);
                    // Some points sit exactly on the cell diagonal.
                    if (k < 35)
                        dt = (ds == 0) ? 0 : ONE - ds;
                    else
                        dt = $urandom_range(0, ONE - 1);
                    query_cell($urandom_range(0, s - 2), $urandom_range(0, s - 2), ds, dt);
                end
                else if (k < 85)
                    query_cell(rim_index(s), rim_index(s), $urandom_range(0, ONE - 1),
                               $urandom_range(0, ONE - 1));
                else
                    send_query(hftq_pkg::CRD_W'($urandom), hftq_pkg::CRD_W'($urandom));
            end
        end

        settle();
        if (model.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/hftq_pkg.sv
rtl/core/hftq_ram.sv
rtl/core/hftq_map.sv
rtl/core/hftq_store.sv
rtl/core/hftq_interp.sv
rtl/core/heightfield_triangle_height_query.sv
sim/heightfield_triangle_height_query_tb.sv
